### rtl/core/pbd_pkg.sv
// Shared constants, request and status codes, and types for the pool-backed deque.
`default_nettype none

package pbd_pkg;

    // Pool geometry
    localparam int POOL_DEPTH  = 16;
    localparam int ITEM_BITS   = 32;
    localparam int SLOT_BITS   = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam int COUNT_BITS  = $clog2(POOL_DEPTH + 1);

    // Fixed field widths
    localparam int REQ_BITS    = 3;
    localparam int STATUS_BITS = 2;
    localparam int CAP_BITS    = 5;
    localparam int CMP_BITS    = (COUNT_BITS > CAP_BITS) ? COUNT_BITS : CAP_BITS;

    // Request codes
    localparam logic [REQ_BITS-1:0] REQ_PUSH_BACK  = 3'd0;
    localparam logic [REQ_BITS-1:0] REQ_PUSH_FRONT = 3'd1;
    localparam logic [REQ_BITS-1:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [REQ_BITS-1:0] REQ_PEEK_FRONT = 3'd3;
    localparam logic [REQ_BITS-1:0] REQ_CLEAR      = 3'd4;

    // Status codes
    localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd2;

    // Reset capacity
    localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    // Write port controls for the slot store
    typedef struct packed {
        logic                 data_we;
        logic [SLOT_BITS-1:0] data_addr;
        logic [ITEM_BITS-1:0] data_wdata;
        logic                 link_we;
        logic [SLOT_BITS-1:0] link_addr;
        logic [SLOT_BITS-1:0] link_wdata;
    } t_mem_wr;

endpackage

`default_nettype wire

### rtl/core/pbd_req_if.sv
// Request channel: valid, ready and one request beat.
`default_nettype none

interface pbd_req_if;
    logic                          valid;
    logic                          ready;
    logic [pbd_pkg::REQ_BITS-1:0]  req_type;
    logic [pbd_pkg::ITEM_BITS-1:0] item_data;

    modport source (output valid, output req_type, output item_data, input ready);
    modport sink   (input valid, input req_type, input item_data, output ready);
endinterface

`default_nettype wire

### rtl/core/pbd_rsp_if.sv
// Response channel: valid, ready and one result beat.
`default_nettype none

interface pbd_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [pbd_pkg::STATUS_BITS-1:0] status;
    logic [pbd_pkg::ITEM_BITS-1:0]   data_out;
    logic [pbd_pkg::COUNT_BITS-1:0]  entry_count;
    logic                            list_empty;

    modport source (output valid, output status, output data_out, output entry_count,
                    output list_empty, input ready);
    modport sink   (input valid, input status, input data_out, input entry_count,
                    input list_empty, output ready);
endinterface

`default_nettype wire

### rtl/core/pbd_cfg_if.sv
// Configuration write channel carrying the capacity register.
`default_nettype none

interface pbd_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [pbd_pkg::CAP_BITS-1:0] capacity;

    modport source (output valid, output capacity, input ready);
    modport sink   (input valid, input capacity, output ready);
endinterface

`default_nettype wire

### rtl/core/pool_backed_deque.sv
// Pool-backed deque: linked list of items held in a fixed pool of memory slots.
// An accepted request beat is captured in r_req and r_item and the sequencer enters S_EXEC;
// its result is registered in the output beat once S_EXEC finds the output register free.
// One request is in flight at a time: the head slot is read from memory in the accept cycle
// and the list is updated and written back in S_EXEC. Reset clears the used-slot bitmap,
// head, tail and count and sets capacity to 16 at once; the slot memories are not cleared.
`default_nettype none

module pool_backed_deque (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    pbd_req_if.sink    i_req,
    pbd_rsp_if.source  o_rsp,
    pbd_cfg_if.sink    i_cfg
);

    pbd_pkg::t_state                     r_state, n_state;
    logic [pbd_pkg::REQ_BITS-1:0]        r_req;
    logic [pbd_pkg::ITEM_BITS-1:0]       r_item;
    logic [pbd_pkg::CAP_BITS-1:0]        r_capacity;
    logic [pbd_pkg::POOL_DEPTH-1:0]      r_used, n_used;
    logic [pbd_pkg::SLOT_BITS-1:0]       r_head, n_head;
    logic [pbd_pkg::SLOT_BITS-1:0]       r_tail, n_tail;
    logic [pbd_pkg::COUNT_BITS-1:0]      r_count, n_count;

    logic                                r_out_valid;
    logic [pbd_pkg::STATUS_BITS-1:0]     r_out_status, n_status;
    logic [pbd_pkg::ITEM_BITS-1:0]       r_out_data, n_data;
    logic [pbd_pkg::COUNT_BITS-1:0]      r_out_count;
    logic                                r_out_empty;

    pbd_pkg::t_mem_wr                    mem_wr;
    logic [pbd_pkg::ITEM_BITS-1:0]       rd_data;
    logic [pbd_pkg::SLOT_BITS-1:0]       rd_link;

    logic                                req_fire;
    logic                                out_free;
    logic                                exec_fire;
    logic [pbd_pkg::CMP_BITS-1:0]        eff_cap;
    logic                                free_found;
    logic [pbd_pkg::SLOT_BITS-1:0]       free_slot;
    logic                                push_full;

    // Slot memories
    pbd_store u_store (
        .i_clk     (i_clk),
        .i_wr      (mem_wr),
        .i_rd_addr (r_head),
        .o_rd_data (rd_data),
        .o_rd_link (rd_link)
    );

    // Handshakes
    assign i_req.ready = (r_state == pbd_pkg::S_IDLE);
    assign req_fire    = i_req.valid && i_req.ready;
    assign out_free    = !r_out_valid || o_rsp.ready;
    assign exec_fire   = (r_state == pbd_pkg::S_EXEC) && out_free;
    assign i_cfg.ready = 1'b1;

    // Clamp capacity to the pool depth
    always_comb begin
        if (pbd_pkg::CMP_BITS'(r_capacity) > pbd_pkg::CMP_BITS'(pbd_pkg::POOL_DEPTH)) begin
            eff_cap = pbd_pkg::CMP_BITS'(pbd_pkg::POOL_DEPTH);
        end else begin
            eff_cap = pbd_pkg::CMP_BITS'(r_capacity);
        end
    end

    // Find the lowest free slot below capacity
    always_comb begin
        free_found = 1'b0;
        free_slot  = '0;
        for (int i = pbd_pkg::POOL_DEPTH - 1; i >= 0; i--) begin
            if (!r_used[i] && (pbd_pkg::CMP_BITS'(i) < eff_cap)) begin
                free_found = 1'b1;
                free_slot  = pbd_pkg::SLOT_BITS'(i);
            end
        end
    end

    assign push_full = (pbd_pkg::CMP_BITS'(r_count) >= eff_cap) || !free_found;

    // Execute the held request against the list state
    always_comb begin
        n_used   = r_used;
        n_head   = r_head;
        n_tail   = r_tail;
        n_count  = r_count;
        n_status = pbd_pkg::ST_OK;
        n_data   = '0;
        mem_wr   = '0;
        mem_wr.data_addr  = free_slot;
        mem_wr.data_wdata = r_item;
        case (r_req)
            pbd_pkg::REQ_PUSH_BACK, pbd_pkg::REQ_PUSH_FRONT: begin
                if (push_full) begin
                    n_status = pbd_pkg::ST_FULL;
                end else begin
                    mem_wr.data_we    = exec_fire;
                    n_used[free_slot] = 1'b1;
                    n_count           = r_count + 1'b1;
                    if (r_count == '0) begin
                        n_head = free_slot;
                        n_tail = free_slot;
                    end else if (r_req == pbd_pkg::REQ_PUSH_BACK) begin
                        mem_wr.link_we    = exec_fire;
                        mem_wr.link_addr  = r_tail;
                        mem_wr.link_wdata = free_slot;
                        n_tail            = free_slot;
                    end else begin
                        mem_wr.link_we    = exec_fire;
                        mem_wr.link_addr  = free_slot;
                        mem_wr.link_wdata = r_head;
                        n_head            = free_slot;
                    end
                end
            end
            pbd_pkg::REQ_POP_FRONT, pbd_pkg::REQ_PEEK_FRONT: begin
                if (r_count == '0) begin
                    n_status = pbd_pkg::ST_EMPTY;
                end else begin
                    n_data = rd_data;
                    if (r_req == pbd_pkg::REQ_POP_FRONT) begin
                        n_used[r_head] = 1'b0;
                        n_count        = r_count - 1'b1;
                        if (n_count != '0) begin
                            n_head = rd_link;
                        end
                    end
                end
            end
            pbd_pkg::REQ_CLEAR: begin
                n_used  = '0;
                n_head  = '0;
                n_tail  = '0;
                n_count = '0;
            end
            default: begin
            end
        endcase
    end

    // Sequence: accept, then execute once the output register is free
    always_comb begin
        n_state = r_state;
        case (r_state)
            pbd_pkg::S_IDLE: begin
                if (req_fire) begin
                    n_state = pbd_pkg::S_EXEC;
                end
            end
            pbd_pkg::S_EXEC: begin
                if (out_free) begin
                    n_state = pbd_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pbd_pkg::S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pbd_pkg::S_IDLE;
            r_capacity  <= pbd_pkg::CAP_RESET;
            r_used      <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid && i_cfg.ready) begin
                r_capacity <= i_cfg.capacity;
            end
            if (exec_fire) begin
                r_used      <= n_used;
                r_head      <= n_head;
                r_tail      <= n_tail;
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Capture the request beat
    always_ff @(posedge i_clk) begin
        if (req_fire) begin
            r_req  <= i_req.req_type;
            r_item <= i_req.item_data;
        end
    end

    // Load the result beat
    always_ff @(posedge i_clk) begin
        if (exec_fire) begin
            r_out_status <= n_status;
            r_out_data   <= n_data;
            r_out_count  <= n_count;
            r_out_empty  <= (n_count == '0);
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.data_out    = r_out_data;
    assign o_rsp.entry_count = r_out_count;
    assign o_rsp.list_empty  = r_out_empty;

`ifndef ASSERT_OFF
    a_count_matches_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_used) == int'(r_count))
        else $error("live count differs from used-slot bitmap");

    a_head_is_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) |-> r_used[r_head])
        else $error("head slot of a non-empty list is not marked used");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_count) <= pbd_pkg::POOL_DEPTH)
        else $error("live count exceeds pool depth");

    a_accept_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_fire |=> (r_state == pbd_pkg::S_EXEC))
        else $error("accepted request did not enter execute");

    a_result_from_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == pbd_pkg::S_EXEC))
        else $error("result loaded outside execute");
`endif

endmodule

`default_nettype wire

### rtl/core/pbd_store.sv
// Slot store: item data memory and forward link memory, registered reads.
`default_nettype none

module pbd_store (
    input  wire logic                            i_clk,
    input  wire pbd_pkg::t_mem_wr                i_wr,
    input  wire logic [pbd_pkg::SLOT_BITS-1:0]   i_rd_addr,
    output logic      [pbd_pkg::ITEM_BITS-1:0]   o_rd_data,
    output logic      [pbd_pkg::SLOT_BITS-1:0]   o_rd_link
);

    logic [pbd_pkg::ITEM_BITS-1:0] r_slot_data [pbd_pkg::POOL_DEPTH];
    logic [pbd_pkg::SLOT_BITS-1:0] r_next_link [pbd_pkg::POOL_DEPTH];
    logic [pbd_pkg::ITEM_BITS-1:0] r_rd_data;
    logic [pbd_pkg::SLOT_BITS-1:0] r_rd_link;

    // Write item data
    always_ff @(posedge i_clk) begin
        if (i_wr.data_we) begin
            r_slot_data[i_wr.data_addr] <= i_wr.data_wdata;
        end
    end

    // Write forward links
    always_ff @(posedge i_clk) begin
        if (i_wr.link_we) begin
            r_next_link[i_wr.link_addr] <= i_wr.link_wdata;
        end
    end

    // Read the addressed slot every cycle
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_slot_data[i_rd_addr];
        r_rd_link <= r_next_link[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;
    assign o_rd_link = r_rd_link;

endmodule

`default_nettype wire

### dv/tb.sv
// Self-checking testbench for pool_backed_deque: directed table, then random capacity phases.
`timescale 1ns / 1ps

module tb;

    localparam int CLK_HALF       = 6;
    localparam int RESET_CYCLES   = 5;
    localparam int DIR_ROWS       = 25;
    localparam int RAND_ITEMS     = 1525;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_SHOWN      = 10;
    localparam int END_SETTLE     = 8;
    localparam int EXP_DEPTH      = 64;

    // Request codes the block ignores
    localparam logic [pbd_pkg::REQ_BITS-1:0] REQ_RSVD_LO  = 3'd5;
    localparam logic [pbd_pkg::REQ_BITS-1:0] REQ_RSVD_MID = 3'd6;
    localparam logic [pbd_pkg::REQ_BITS-1:0] REQ_RSVD_HI  = 3'd7;

    // Capacity settings of interest
    localparam logic [pbd_pkg::CAP_BITS-1:0] CAP_NONE = 5'd0;
    localparam logic [pbd_pkg::CAP_BITS-1:0] CAP_MIN  = 5'd1;
    localparam logic [pbd_pkg::CAP_BITS-1:0] CAP_TWO  = 5'd2;
    localparam logic [pbd_pkg::CAP_BITS-1:0] CAP_MAX  = 5'd31;

    typedef struct packed {
        logic [pbd_pkg::STATUS_BITS-1:0] status;
        logic [pbd_pkg::ITEM_BITS-1:0]   data_out;
        logic [pbd_pkg::COUNT_BITS-1:0]  entry_count;
        logic                            list_empty;
    } t_deque_result;

    typedef struct packed {
        logic                           cap_wr;
        logic [pbd_pkg::CAP_BITS-1:0]   cap_val;
        logic [pbd_pkg::REQ_BITS-1:0]   kind;
        logic [pbd_pkg::ITEM_BITS-1:0]  item;
        logic                           typed;
        t_deque_result                  want;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;

    pbd_req_if req_if ();
    pbd_rsp_if rsp_if ();
    pbd_cfg_if cfg_if ();

    pool_backed_deque uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .i_cfg   (cfg_if)
    );

    // Shadow copy of the list kept by the predictor
    logic [pbd_pkg::ITEM_BITS-1:0]  pool_item [pbd_pkg::POOL_DEPTH];
    logic [pbd_pkg::SLOT_BITS-1:0]  pool_next [pbd_pkg::POOL_DEPTH];
    logic [pbd_pkg::SLOT_BITS-1:0]  pool_prev [pbd_pkg::POOL_DEPTH];
    logic [pbd_pkg::POOL_DEPTH-1:0] pool_busy;
    logic [pbd_pkg::SLOT_BITS-1:0]  front_slot;
    logic [pbd_pkg::SLOT_BITS-1:0]  back_slot;
    logic [pbd_pkg::COUNT_BITS-1:0] live_count;
    logic [pbd_pkg::CAP_BITS-1:0]   cap_limit;

    // Expected results in order: written by the sender, consumed by the checker
    t_deque_result exp_buf [EXP_DEPTH];
    int            exp_wr_cnt  = 0;
    int            exp_rd_cnt  = 0;
    t_dir_row      dir_rows [DIR_ROWS];
    int            mismatches  = 0;
    int            rsp_hold    = 0;
    int            idle_cycles = 0;
    logic          no_idle;

    // Clock
    initial i_clk = 1'b0;
    always #CLK_HALF i_clk = ~i_clk;

    // Gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 88) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Advance the shadow list by one request and return its result
    function automatic t_deque_result apply_request(
            input logic [pbd_pkg::REQ_BITS-1:0]  kind,
            input logic [pbd_pkg::ITEM_BITS-1:0] item);
        t_deque_result res;
        int            limit;
        int            slot;
        res.status   = pbd_pkg::ST_OK;
        res.data_out = '0;
        limit = (int'(cap_limit) > pbd_pkg::POOL_DEPTH) ? pbd_pkg::POOL_DEPTH
                                                       : int'(cap_limit);
        slot = -1;
        for (int i = limit - 1; i >= 0; i--) begin
            if (!pool_busy[i]) slot = i;
        end
        case (kind)
            pbd_pkg::REQ_PUSH_BACK, pbd_pkg::REQ_PUSH_FRONT: begin
                if (int'(live_count) >= limit || slot < 0) begin
                    res.status = pbd_pkg::ST_FULL;
                end else begin
                    pool_item[slot] = item;
                    pool_busy[slot] = 1'b1;
                    if (live_count == 0) begin
                        pool_next[slot] = '0;
                        pool_prev[slot] = '0;
                        front_slot = pbd_pkg::SLOT_BITS'(slot);
                        back_slot  = pbd_pkg::SLOT_BITS'(slot);
                    end else if (kind == pbd_pkg::REQ_PUSH_BACK) begin
                        pool_next[slot]      = '0;
                        pool_prev[slot]      = back_slot;
                        pool_next[back_slot] = pbd_pkg::SLOT_BITS'(slot);
                        back_slot            = pbd_pkg::SLOT_BITS'(slot);
                    end else begin
                        pool_prev[slot]       = '0;
                        pool_next[slot]       = front_slot;
                        pool_prev[front_slot] = pbd_pkg::SLOT_BITS'(slot);
                        front_slot            = pbd_pkg::SLOT_BITS'(slot);
                    end
                    live_count = live_count + 1'b1;
                end
            end
            pbd_pkg::REQ_POP_FRONT, pbd_pkg::REQ_PEEK_FRONT: begin
                if (live_count == 0) begin
                    res.status = pbd_pkg::ST_EMPTY;
                end else begin
                    res.data_out = pool_item[front_slot];
                    if (kind == pbd_pkg::REQ_POP_FRONT) begin
                        pool_busy[front_slot] = 1'b0;
                        live_count = live_count - 1'b1;
                        if (live_count != 0) begin
                            front_slot = pool_next[front_slot];
                            pool_prev[front_slot] = '0;
                        end
                    end
                end
            end
            pbd_pkg::REQ_CLEAR: begin
                pool_busy  = '0;
                front_slot = '0;
                back_slot  = '0;
                live_count = '0;
            end
            default: begin
            end
        endcase
        res.entry_count = live_count;
        res.list_empty  = (live_count == 0);
        return res;
    endfunction

    function automatic void check_field(input string field,
                                        input logic [pbd_pkg::ITEM_BITS-1:0] want,
                                        input logic [pbd_pkg::ITEM_BITS-1:0] got);
        if (want !== got) begin
            if (mismatches < MAX_SHOWN)
                $display("mismatch on %s: expected %h, actual %h", field, want, got);
            mismatches++;
        end
    endfunction

    // Queue one expected result behind the earlier ones
    function automatic void put_expect(input t_deque_result res);
        exp_buf[exp_wr_cnt % EXP_DEPTH] = res;
        exp_wr_cnt++;
    endfunction

    // Drive one request beat, hold it until accepted, then predict its result
    task automatic send_req(input logic [pbd_pkg::REQ_BITS-1:0] kind,
                            input logic [pbd_pkg::ITEM_BITS-1:0] item,
                            output t_deque_result predicted);
        int gap;
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid     <= 1'b1;
        req_if.req_type  <= kind;
        req_if.item_data <= item;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        predicted = apply_request(kind, item);
    endtask

    // Drop valid and hold off until every expected beat has come back
    task automatic drain_results();
        if (req_if.valid) req_if.valid <= 1'b0;
        while (exp_wr_cnt != exp_rd_cnt) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [pbd_pkg::CAP_BITS-1:0] value);
        drain_results();
        cfg_if.valid    <= 1'b1;
        cfg_if.capacity <= value;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        cfg_if.valid <= 1'b0;
        cap_limit = value;
    endtask

    // Response side: random stalls unless a quiet stretch is on
    always @(posedge i_clk) begin
        if (rsp_hold > 0) begin
            rsp_hold     <= rsp_hold - 1;
            rsp_if.ready <= 1'b0;
        end else if (!no_idle && $urandom_range(0, 3) == 0) begin
            rsp_hold     <= pick_gap();
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= 1'b1;
        end
    end

    // Compare each result beat with the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_deque_result want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (exp_wr_cnt == exp_rd_cnt) begin
                if (mismatches < MAX_SHOWN)
                    $display("unexpected result beat: status %h data %h count %0d empty %b",
                             rsp_if.status, rsp_if.data_out, rsp_if.entry_count,
                             rsp_if.list_empty);
                mismatches++;
            end else begin
                want = exp_buf[exp_rd_cnt % EXP_DEPTH];
                exp_rd_cnt++;
                check_field("status", pbd_pkg::ITEM_BITS'(want.status),
                            pbd_pkg::ITEM_BITS'(rsp_if.status));
                check_field("data_out", want.data_out, rsp_if.data_out);
                check_field("entry_count", pbd_pkg::ITEM_BITS'(want.entry_count),
                            pbd_pkg::ITEM_BITS'(rsp_if.entry_count));
                check_field("list_empty", pbd_pkg::ITEM_BITS'(want.list_empty),
                            pbd_pkg::ITEM_BITS'(rsp_if.list_empty));
            end
        end
    end

    // Watchdog: end the run after too long with no beat on any channel
    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
            (cfg_if.valid && cfg_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        t_deque_result                 predicted;
        logic [pbd_pkg::REQ_BITS-1:0]  kind;
        logic [pbd_pkg::ITEM_BITS-1:0] item;
        logic [pbd_pkg::CAP_BITS-1:0]  cap;
        int                            pick;
        int                            push_pct;
        int                            phase;
        int                            phase_len;
        int                            sent;

        // Known values on the reset, request and config inputs from time zero
        i_rst_n          <= 1'b0;
        req_if.valid     <= 1'b0;
        req_if.req_type  <= pbd_pkg::REQ_PUSH_BACK;
        req_if.item_data <= '0;
        cfg_if.valid     <= 1'b0;
        cfg_if.capacity  <= pbd_pkg::CAP_RESET;
        no_idle     = 1'b0;

        // Shadow state after reset
        for (int i = 0; i < pbd_pkg::POOL_DEPTH; i++) begin
            pool_item[i] = '0;
            pool_next[i] = '0;
            pool_prev[i] = '0;
        end
        pool_busy  = '0;
        front_slot = '0;
        back_slot  = '0;
        live_count = '0;
        cap_limit  = pbd_pkg::CAP_RESET;

        // Directed table: capacity write, request, and a typed result where obvious
        dir_rows[0]  = '{1'b0, CAP_NONE, pbd_pkg::REQ_POP_FRONT, 32'h0, 1'b1,
                         '{pbd_pkg::ST_EMPTY, 32'h0, 5'd0, 1'b1}};
        dir_rows[1]  = '{1'b0, CAP_NONE, pbd_pkg::REQ_PEEK_FRONT, 32'h0, 1'b1,
                         '{pbd_pkg::ST_EMPTY, 32'h0, 5'd0, 1'b1}};
        dir_rows[2]  = '{1'b0, CAP_NONE, pbd_pkg::REQ_PUSH_BACK, 32'h0000_0000, 1'b1,
                         '{pbd_pkg::ST_OK, 32'h0, 5'd1, 1'b0}};
        dir_rows[3]  = '{1'b0, CAP_NONE, pbd_pkg::REQ_PUSH_BACK, 32'hFFFF_FFFF, 1'b1,
                         '{pbd_pkg::ST_OK, 32'h0, 5'd2, 1'b0}};
        dir_rows[4]  = '{1'b0, CAP_NONE, pbd_pkg::REQ_PUSH_FRONT, 32'hA5A5_A5A5, 1'b0, '0};
        dir_rows[5]  = '{1'b0, CAP_NONE, pbd_pkg::REQ_PEEK_FRONT, 32'h0, 1'b0, '0};
        dir_rows[6]  = '{1'b0, CAP_NONE, REQ_RSVD_LO, 32'hFFFF_FFFF, 1'b0, '0};
        dir_rows[7]  = '{1'b0, CAP_NONE, REQ_RSVD_HI, 32'h1234_5678, 1'b0, '0};
        dir_rows[8]  = '{1'b0, CAP_NONE, pbd_pkg::REQ_POP_FRONT, 32'h0, 1'b0, '0};
        dir_rows[9]  = '{1'b0, CAP_NONE, REQ_RSVD_MID, 32'h0, 1'b0, '0};
        dir_rows[10] = '{1'b0, CAP_NONE, pbd_pkg::REQ_CLEAR, 32'h0, 1'b1,
                         '{pbd_pkg::ST_OK, 32'h0, 5'd0, 1'b1}};
        dir_rows[11] = '{1'b1, CAP_MIN, pbd_pkg::REQ_PUSH_BACK, 32'h1234_5678, 1'b1,
                         '{pbd_pkg::ST_OK, 32'h0, 5'd1, 1'b0}};
        dir_rows[12] = '{1'b0, CAP_NONE, pbd_pkg::REQ_PUSH_FRONT, 32'h0000_0001, 1'b1,
                         '{pbd_pkg::ST_FULL, 32'h0, 5'd1, 1'b0}};
        dir_rows[13] = '{1'b0, CAP_NONE, pbd_pkg::REQ_POP_FRONT, 32'h0, 1'b1,
                         '{pbd_pkg::ST_OK, 32'h1234_5678, 5'd0, 1'b1}};
        dir_rows[14] = '{1'b1, CAP_NONE, pbd_pkg::REQ_PUSH_BACK, 32'hFFFF_FFFF, 1'b1,
                         '{pbd_pkg::ST_FULL, 32'h0, 5'd0, 1'b1}};
        dir_rows[15] = '{1'b0, CAP_NONE, pbd_pkg::REQ_PUSH_FRONT, 32'h0, 1'b1,
                         '{pbd_pkg::ST_FULL, 32'h0, 5'd0, 1'b1}};
        dir_rows[16] = '{1'b1, CAP_MAX, pbd_pkg::REQ_PUSH_FRONT, 32'h5A5A_5A5A, 1'b0, '0};
        dir_rows[17] = '{1'b0, CAP_NONE, pbd_pkg::REQ_PUSH_BACK, 32'hC3C3_C3C3, 1'b0, '0};
        dir_rows[18] = '{1'b0, CAP_NONE, pbd_pkg::REQ_POP_FRONT, 32'h0, 1'b0, '0};
        dir_rows[19] = '{1'b1, pbd_pkg::CAP_RESET, pbd_pkg::REQ_CLEAR, 32'h0, 1'b1,
                         '{pbd_pkg::ST_OK, 32'h0, 5'd0, 1'b1}};
        dir_rows[20] = '{1'b0, CAP_NONE, pbd_pkg::REQ_PUSH_BACK, 32'h0000_0001, 1'b0, '0};
        dir_rows[21] = '{1'b0, CAP_NONE, pbd_pkg::REQ_PUSH_FRONT, 32'h8000_0000, 1'b0, '0};
        dir_rows[22] = '{1'b0, CAP_NONE, pbd_pkg::REQ_PUSH_BACK, 32'h7FFF_FFFF, 1'b0, '0};
        // Capacity dropped below the live count: the push is refused
        dir_rows[23] = '{1'b1, CAP_TWO, pbd_pkg::REQ_PUSH_FRONT, 32'hDEAD_BEEF, 1'b1,
                         '{pbd_pkg::ST_FULL, 32'h0, 5'd3, 1'b0}};
        dir_rows[24] = '{1'b0, CAP_NONE, pbd_pkg::REQ_POP_FRONT, 32'h0, 1'b0, '0};

        // Reset
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed table
        for (int r = 0; r < DIR_ROWS; r++) begin
            if (dir_rows[r].cap_wr) write_capacity(dir_rows[r].cap_val);
            send_req(dir_rows[r].kind, dir_rows[r].item, predicted);
            put_expect(dir_rows[r].typed ? dir_rows[r].want : predicted);
        end

        // Random phases, each with its own capacity, push bias and idling
        sent  = 0;
        phase = 0;
        while (sent < RAND_ITEMS) begin
            case (phase)
                0: cap = CAP_MIN;
                1: cap = pbd_pkg::CAP_RESET;
                2: cap = CAP_MAX;
                3: cap = CAP_NONE;
                default: begin
                    pick = $urandom_range(0, 9);
                    if (pick == 0) cap = CAP_NONE;
                    else if (pick == 1)
                        cap = pbd_pkg::CAP_BITS'($urandom_range(pbd_pkg::POOL_DEPTH + 1, 31));
                    else cap = pbd_pkg::CAP_BITS'($urandom_range(1, pbd_pkg::POOL_DEPTH));
                end
            endcase
            write_capacity(cap);
            no_idle   = ($urandom_range(0, 3) == 0);
            push_pct  = $urandom_range(25, 70);
            phase_len = (cap == CAP_NONE) ? 20 : $urandom_range(60, 200);
            for (int k = 0; k < phase_len && sent < RAND_ITEMS; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < push_pct) begin
                    kind = ($urandom_range(0, 4) < 3) ? pbd_pkg::REQ_PUSH_BACK
                                                      : pbd_pkg::REQ_PUSH_FRONT;
                end else begin
                    pick = $urandom_range(0, 99);
                    if (pick < 4) kind = pbd_pkg::REQ_CLEAR;
                    else if (pick < 9)
                        kind = pbd_pkg::REQ_BITS'($urandom_range(REQ_RSVD_LO, REQ_RSVD_HI));
                    else if (pick < 30) kind = pbd_pkg::REQ_PEEK_FRONT;
                    else kind = pbd_pkg::REQ_POP_FRONT;
                end
                pick = $urandom_range(0, 15);
                if (pick == 0) item = '0;
                else if (pick == 1) item = '1;
                else item = $urandom;
                send_req(kind, item, predicted);
                put_expect(predicted);
                sent++;
                // Now and then hold the sender until the block has answered everything
                if ($urandom_range(0, 199) == 0) drain_results();
            end
            phase++;
        end

        // Wait out the last results, then report
        no_idle = 1'b0;
        drain_results();
        repeat (END_SETTLE) @(posedge i_clk);
        if (mismatches == 0 && exp_wr_cnt == exp_rd_cnt) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

### pool_backed_deque.f
rtl/core/pbd_pkg.sv
rtl/core/pbd_req_if.sv
rtl/core/pbd_rsp_if.sv
rtl/core/pbd_cfg_if.sv
rtl/core/pbd_store.sv
rtl/core/pool_backed_deque.sv
dv/tb.sv
